// File: hw/rtl/connection_string_tokenizer_core_macros.svh
// Assertion macros used by the checker file of the tokenizer core.
`ifndef CONNECTION_STRING_TOKENIZER_CORE_MACROS_SVH
`define CONNECTION_STRING_TOKENIZER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer core check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer core check failed");

`endif

// File: hw/rtl/cst_pkg.sv
// Types, character codes and helpers shared by the tokenizer core files.
`timescale 1ns / 1ps
package cst_pkg;

  localparam int MAX_LEN_DEF = 1023;
  localparam int LEN_W       = 10;
  localparam int CHAR_W      = 16;
  localparam logic [LEN_W-1:0] LEN_SAT     = 10'd1023;
  localparam logic [LEN_W-1:0] MAX_VAL_RST = 10'd1023;

  localparam logic [CHAR_W-1:0] CH_LBRACE    = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_RBRACE    = 16'h007D;
  localparam logic [CHAR_W-1:0] CH_SEMI      = 16'h003B;
  localparam logic [CHAR_W-1:0] CH_EQUALS    = 16'h003D;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_NUL       = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_TAB       = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_CR        = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_LF        = 16'h000A;

  localparam logic REG_MAX_VALUE_LEN = 1'b0;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_KEY    = 3'd1,
    PH_KEY_WS = 3'd2,
    PH_VAL_WS = 3'd3,
    PH_VAL    = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    ST_PARSING      = 4'd0,
    ST_ACCEPTED     = 4'd1,
    ST_KEY_BSLASH   = 4'd2,
    ST_KEY_SEMI     = 4'd3,
    ST_NUL          = 4'd4,
    ST_INNER_BRACE  = 4'd5,
    ST_UNCLOSED     = 4'd6,
    ST_NO_EQUALS    = 4'd7,
    ST_NO_VALUE     = 4'd8,
    ST_VALUE_LONG   = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    ROLE_OTHER = 2'd0,
    ROLE_KEY   = 2'd1,
    ROLE_VALUE = 2'd2
  } role_t;

  typedef struct packed {
    phase_t  phase;
    logic    brace_open;
    logic    at_start;
    status_t final_status;
  } ctrl_t;

  typedef struct packed {
    role_t            role;
    logic             kend;
    logic             vend;
    logic [LEN_W-1:0] len;
    status_t          status;
  } result_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// File: hw/rtl/cst_cfg.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
module cst_cfg
  import cst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [LEN_W-1:0] max_value_len
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_VALUE_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value_len <= MAX_VAL_RST;
    end else if (wr_en) begin
      max_value_len <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_VALUE_LEN: prdata = {{(32-LEN_W){1'b0}}, max_value_len};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// File: hw/rtl/cst_step.sv
// Next-state and result logic for one character of the connection string.
`timescale 1ns / 1ps
module cst_step
  import cst_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int CW      = $clog2(MAX_LEN + 2)
) (
  input  ctrl_t             cur,
  input  logic [CW-1:0]     count,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  input  logic [LEN_W-1:0]  max_value_len,
  output ctrl_t             nxt,
  output logic [CW-1:0]     count_next,
  output result_t           res
);

  function automatic logic [LEN_W-1:0] sat_len(input logic [CW-1:0] c);
    return (32'(c) > 32'(LEN_SAT)) ? LEN_SAT : LEN_W'(c);
  endfunction

  function automatic logic too_long(input logic [CW-1:0] c, input logic [LEN_W-1:0] lim);
    return (32'(c) > 32'(lim)) || (32'(c) > 32'(MAX_LEN));
  endfunction

  logic          do_key;
  logic          do_val;
  logic          first;
  logic          blank;
  logic [CW-1:0] cnt;

  always_comb begin
    nxt    = cur;
    cnt    = count;
    res    = '0;
    do_key = 1'b0;
    do_val = 1'b0;
    first  = 1'b0;
    blank  = is_blank(char_code);

    if (cur.final_status == ST_PARSING) begin
      case (cur.phase)
        PH_SKIP: begin
          if (blank || char_code == CH_SEMI) begin
          end else if (char_code == CH_NUL) begin
            nxt.final_status = ST_ACCEPTED;
          end else begin
            nxt.phase      = PH_KEY;
            cnt            = '0;
            nxt.brace_open = 1'b0;
            nxt.at_start   = 1'b1;
            do_key         = 1'b1;
          end
        end
        PH_KEY: do_key = 1'b1;
        PH_KEY_WS: begin
          if (blank) begin
          end else if (char_code == CH_EQUALS) begin
            nxt.phase = PH_VAL_WS;
          end else begin
            nxt.final_status = ST_NO_EQUALS;
          end
        end
        PH_VAL_WS: begin
          if (blank) begin
          end else if (char_code == CH_NUL) begin
            nxt.final_status = ST_NO_VALUE;
          end else begin
            nxt.phase      = PH_VAL;
            cnt            = '0;
            nxt.brace_open = 1'b0;
            nxt.at_start   = 1'b1;
            do_val         = 1'b1;
          end
        end
        PH_VAL: do_val = 1'b1;
        default: begin
        end
      endcase

      if (do_key) begin
        first        = nxt.at_start;
        nxt.at_start = 1'b0;
        if (char_code == CH_BACKSLASH) begin
          nxt.final_status = ST_KEY_BSLASH;
        end else if (blank || char_code == CH_EQUALS) begin
          if (nxt.brace_open) begin
            res.role = ROLE_KEY;
            if (32'(cnt) < 32'(MAX_LEN) + 1) cnt = cnt + CW'(1);
          end else begin
            res.kend  = 1'b1;
            res.len   = sat_len(cnt);
            nxt.phase = blank ? PH_KEY_WS : PH_VAL_WS;
          end
        end else if (char_code == CH_SEMI) begin
          if (nxt.brace_open) begin
            res.role = ROLE_KEY;
            if (32'(cnt) < 32'(MAX_LEN) + 1) cnt = cnt + CW'(1);
          end else begin
            nxt.final_status = ST_KEY_SEMI;
          end
        end else if (char_code == CH_NUL) begin
          nxt.final_status = ST_NUL;
        end else if (char_code == CH_LBRACE && first) begin
          nxt.brace_open = 1'b1;
        end else if (char_code == CH_LBRACE && nxt.brace_open) begin
          nxt.final_status = ST_INNER_BRACE;
        end else if (char_code == CH_RBRACE && nxt.brace_open) begin
          nxt.brace_open = 1'b0;
          res.kend       = 1'b1;
          res.len        = sat_len(cnt);
          nxt.phase      = PH_KEY_WS;
        end else begin
          res.role = ROLE_KEY;
          if (32'(cnt) < 32'(MAX_LEN) + 1) cnt = cnt + CW'(1);
        end
      end

      if (do_val) begin
        first        = nxt.at_start;
        nxt.at_start = 1'b0;
        if (char_code == CH_SEMI && !nxt.brace_open) begin
          res.len = sat_len(cnt);
          if (too_long(cnt, max_value_len)) nxt.final_status = ST_VALUE_LONG;
          else res.vend = 1'b1;
          nxt.phase = PH_SKIP;
        end else if (char_code == CH_NUL) begin
          if (nxt.brace_open) begin
            nxt.final_status = ST_NUL;
          end else begin
            res.len = sat_len(cnt);
            if (too_long(cnt, max_value_len)) nxt.final_status = ST_VALUE_LONG;
            else begin
              res.vend         = 1'b1;
              nxt.final_status = ST_ACCEPTED;
            end
          end
        end else if (char_code == CH_LBRACE && first) begin
          nxt.brace_open = 1'b1;
        end else if (char_code == CH_LBRACE && nxt.brace_open) begin
          nxt.final_status = ST_INNER_BRACE;
        end else if (char_code == CH_RBRACE && nxt.brace_open) begin
          nxt.brace_open = 1'b0;
          res.len        = sat_len(cnt);
          if (too_long(cnt, max_value_len)) nxt.final_status = ST_VALUE_LONG;
          else res.vend = 1'b1;
          nxt.phase = PH_SKIP;
        end else begin
          res.role = ROLE_VALUE;
          if (32'(cnt) < 32'(MAX_LEN) + 1) cnt = cnt + CW'(1);
        end
      end

      if (last_char && nxt.final_status == ST_PARSING) begin
        case (nxt.phase)
          PH_SKIP: nxt.final_status = ST_ACCEPTED;
          PH_KEY: begin
            if (nxt.brace_open) begin
              nxt.final_status = ST_UNCLOSED;
            end else begin
              res.kend         = 1'b1;
              res.len          = sat_len(cnt);
              nxt.final_status = ST_NO_EQUALS;
            end
          end
          PH_KEY_WS: nxt.final_status = ST_NO_EQUALS;
          PH_VAL_WS: nxt.final_status = ST_NO_VALUE;
          PH_VAL: begin
            if (nxt.brace_open) begin
              nxt.final_status = ST_UNCLOSED;
            end else begin
              res.len = sat_len(cnt);
              if (too_long(cnt, max_value_len)) nxt.final_status = ST_VALUE_LONG;
              else begin
                res.vend         = 1'b1;
                nxt.final_status = ST_ACCEPTED;
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (nxt.final_status != ST_PARSING) nxt.phase = PH_DONE;
    end

    res.status = nxt.final_status;
    count_next = cnt;
  end

endmodule

// File: hw/rtl/connection_string_tokenizer_core.sv
// Top level of the connection string tokenizer core.
`timescale 1ns / 1ps
// The block tokenizes a key=value; connection string that arrives as one
// 16-bit character per input transaction, with last_char set on the final one.
// Every input transaction produces exactly one output transaction carrying the
// character role, keyword and value end flags, the token length and the
// sticky status.
// Both channels use valid and ready. An accepted character is held in an input
// register; once the output register is free it is evaluated against the parser
// state and the result is written to the output register. One character is
// accepted per cycle while the receiver keeps taking results, with the single
// state update between the input register and the output register.
// When the receiver stalls, the output register holds its result and the input
// register holds one more character; in_ready then falls until out_ready rises.
// Reset clears the parser to the top-level skip state, empties both registers
// and sets max_value_len to 1023. The register is written through the APB
// port at byte address 0 and should only be changed while the block is idle.
// Once the status is nonzero, later characters report the same status only.
module connection_string_tokenizer_core
  import cst_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        char_role,
  output logic              keyword_end,
  output logic              value_end,
  output logic [LEN_W-1:0]  token_length,
  output logic [3:0]        status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_LEN + 2);

  logic              hold_valid;
  logic [CHAR_W-1:0] hold_char;
  logic              hold_last;
  logic              advance;
  ctrl_t             ctrl;
  ctrl_t             ctrl_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  result_t           res_next;
  result_t           res;
  logic [LEN_W-1:0]  max_value_len;

  cst_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_value_len (max_value_len)
  );

  cst_step #(
    .MAX_LEN (MAX_LEN),
    .CW      (CW)
  ) u_step (
    .cur           (ctrl),
    .count         (count),
    .char_code     (hold_char),
    .last_char     (hold_last),
    .max_value_len (max_value_len),
    .nxt           (ctrl_next),
    .count_next    (count_next),
    .res           (res_next)
  );

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_char <= char_code;
      hold_last <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase        <= PH_SKIP;
      ctrl.brace_open   <= 1'b0;
      ctrl.at_start     <= 1'b1;
      ctrl.final_status <= ST_PARSING;
      count             <= '0;
    end else if (advance) begin
      ctrl  <= ctrl_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign char_role    = res.role;
  assign keyword_end  = res.kend;
  assign value_end    = res.vend;
  assign token_length = res.len;
  assign status       = res.status;

endmodule

// File: hw/rtl/cst_checker.sv
// Port-level checker for the tokenizer core and its bind statement.
`timescale 1ns / 1ps
`include "connection_string_tokenizer_core_macros.svh"
module cst_checker
  import cst_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       char_role,
  input logic             keyword_end,
  input logic             value_end,
  input logic [LEN_W-1:0] token_length,
  input logic [3:0]       status
);

  `CST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(token_length))
  `CST_ASSERT_SAME(a_single_end, out_valid, !(keyword_end && value_end) && char_role != 2'd3)
  `CST_ASSERT_SAME(a_value_end_ok, out_valid && value_end, status == ST_PARSING || status == ST_ACCEPTED)
  `CST_ASSERT_SAME(a_len_zero, out_valid && !keyword_end && !value_end && status != ST_VALUE_LONG, token_length == '0)

endmodule

bind connection_string_tokenizer_core cst_checker u_cst_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .char_role    (char_role),
  .keyword_end  (keyword_end),
  .value_end    (value_end),
  .token_length (token_length),
  .status       (status)
);
